// ===== design/i2cft_pkg.sv =====
package i2cft_pkg;

  // Line symbols, one per output word.
  typedef enum logic [2:0] {
    SYM_START = 3'd0,
    SYM_ZERO  = 3'd1,
    SYM_ONE   = 3'd2,
    SYM_ACK   = 3'd3,
    SYM_STOP  = 3'd4
  } symbol_t;

  // Segments of a frame in sending order.
  typedef enum logic [2:0] {
    SEG_START   = 3'd0,
    SEG_HEADER  = 3'd1,
    SEG_DATA    = 3'd2,
    SEG_SUM     = 3'd3,
    SEG_TRAILER = 3'd4,
    SEG_STOP    = 3'd5
  } seg_t;

  // Configuration register indexes.
  localparam logic REG_HEADER  = 1'b0;
  localparam logic REG_TRAILER = 1'b1;

  localparam logic [7:0] HEADER_RESET  = 8'hA5;
  localparam logic [7:0] TRAILER_RESET = 8'hD5;

  // Bit slot of the acknowledge symbol within a byte.
  localparam logic [3:0] ACK_SLOT = 4'd8;

  // One accepted payload word with everything needed to send its run.
  typedef struct packed {
    logic       open_frame;
    logic       close_frame;
    logic [7:0] header;
    logic [7:0] data;
    logic [7:0] sum;
    logic [7:0] trailer;
  } item_t;

endpackage

// ===== design/i2cft_ser.sv =====
module i2cft_ser (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  output logic              load_ready,
  input  i2cft_pkg::item_t  load_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_symbol,
  output logic              out_last
);

  logic              busy;
  i2cft_pkg::item_t  item;
  i2cft_pkg::seg_t   seg;
  logic [3:0]        bitc;

  logic              advance;
  logic              sym_last;
  logic              load;
  i2cft_pkg::symbol_t sym;
  logic [7:0]        cur_byte;
  i2cft_pkg::seg_t   seg_next;
  logic [3:0]        bitc_next;

  // A symbol moves into the output register when that register is free or taken.
  assign advance    = busy && (!out_valid || out_ready);
  assign load_ready = !busy || (advance && sym_last);
  assign load       = load_valid && load_ready;

  // Byte being sent in the current segment.
  always_comb begin
    case (seg)
      i2cft_pkg::SEG_HEADER:  cur_byte = item.header;
      i2cft_pkg::SEG_DATA:    cur_byte = item.data;
      i2cft_pkg::SEG_SUM:     cur_byte = item.sum;
      i2cft_pkg::SEG_TRAILER: cur_byte = item.trailer;
      default:                cur_byte = item.data;
    endcase
  end

  // Symbol for the current position, MSB first, then the acknowledge slot.
  always_comb begin
    unique case (seg)
      i2cft_pkg::SEG_START: sym = i2cft_pkg::SYM_START;
      i2cft_pkg::SEG_STOP:  sym = i2cft_pkg::SYM_STOP;
      default: begin
        if (bitc == i2cft_pkg::ACK_SLOT) begin
          sym = i2cft_pkg::SYM_ACK;
        end else if (cur_byte[3'(3'd7 - bitc[2:0])]) begin
          sym = i2cft_pkg::SYM_ONE;
        end else begin
          sym = i2cft_pkg::SYM_ZERO;
        end
      end
    endcase
  end

  // The run ends after the stop symbol or, for a word that leaves the frame open, after the payload ack.
  assign sym_last = item.close_frame ? (seg == i2cft_pkg::SEG_STOP)
                                     : (seg == i2cft_pkg::SEG_DATA &&
                                        bitc == i2cft_pkg::ACK_SLOT);

  // Step to the next position of the frame.
  always_comb begin
    seg_next  = seg;
    bitc_next = bitc + 4'd1;
    unique case (seg)
      i2cft_pkg::SEG_START: begin
        seg_next  = i2cft_pkg::SEG_HEADER;
        bitc_next = 4'd0;
      end
      i2cft_pkg::SEG_HEADER, i2cft_pkg::SEG_DATA,
      i2cft_pkg::SEG_SUM, i2cft_pkg::SEG_TRAILER: begin
        if (bitc == i2cft_pkg::ACK_SLOT) begin
          seg_next  = i2cft_pkg::seg_t'(seg + 3'd1);
          bitc_next = 4'd0;
        end
      end
      default: begin
        seg_next  = seg;
        bitc_next = 4'd0;
      end
    endcase
  end

  // Serializer position and the word it works on.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      seg  <= i2cft_pkg::SEG_START;
      bitc <= 4'd0;
    end else if (load) begin
      busy <= 1'b1;
      seg  <= load_item.open_frame ? i2cft_pkg::SEG_START : i2cft_pkg::SEG_DATA;
      bitc <= 4'd0;
    end else if (advance) begin
      busy <= !sym_last;
      seg  <= seg_next;
      bitc <= bitc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= load_item;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_symbol <= sym;
      out_last   <= sym_last;
    end
  end

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> bitc <= i2cft_pkg::ACK_SLOT)
    else $error("bit slot counter out of range");

  a_start_then_header: assert property (@(posedge clk) disable iff (rst)
    advance && !sym_last && seg == i2cft_pkg::SEG_START
    |=> seg == i2cft_pkg::SEG_HEADER && bitc == 4'd0)
    else $error("start symbol not followed by header");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    advance && sym_last |=> out_valid && out_last)
    else $error("end of run not marked on output");

endmodule

// ===== design/i2c_id_frame_transmitter.sv =====
// Sends one write-only I2C-style frame as a run of line symbols, one symbol
// per output word: start, header byte, payload bytes, their 8-bit sum, trailer
// byte and stop, each byte MSB first followed by an acknowledge slot. The
// first payload word while idle opens a frame and a word with tlast closes
// it. The serializer emits one symbol per clock unless m_tready stalls it.
// A middle payload word sends only its byte; an opening word adds start and
// header before it and a closing word adds sum, trailer and stop after it.
// One word waits in an input register while the previous run goes out, so
// runs follow each other directly. m_tlast marks each word's final symbol.
module i2c_id_frame_transmitter (
  input  logic       clk,
  input  logic       rst,
  // Configuration write port.
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_data,
  // Input stream.
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] payload_byte
  input  logic       s_tlast,   // end_of_payload
  // Output stream.
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [2:0] line_symbol, [7:3] zero
  output logic       m_tlast    // last_of_run
);

  logic [7:0]        header_byte;
  logic [7:0]        trailer_byte;
  logic [7:0]        running_sum;
  logic              in_frame;
  logic              pend_valid;
  i2cft_pkg::item_t  pend_item;
  i2cft_pkg::item_t  new_item;
  logic              s_accept;
  logic              load_ready;
  logic [2:0]        symbol;
  logic [7:0]        sum_next;

  assign s_tready = !pend_valid;
  assign s_accept = s_tvalid && s_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte  <= i2cft_pkg::HEADER_RESET;
      trailer_byte <= i2cft_pkg::TRAILER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        i2cft_pkg::REG_HEADER:  header_byte  <= cfg_data;
        i2cft_pkg::REG_TRAILER: trailer_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame state advances as words are accepted.
  assign sum_next = in_frame ? running_sum + s_tdata : s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 8'd0;
      in_frame    <= 1'b0;
    end else if (s_accept) begin
      running_sum <= sum_next;
      in_frame    <= !s_tlast;
    end
  end

  always_comb begin
    new_item.open_frame  = !in_frame;
    new_item.close_frame = s_tlast;
    new_item.header      = header_byte;
    new_item.data        = s_tdata;
    new_item.sum         = sum_next;
    new_item.trailer     = trailer_byte;
  end

  // Input register holding the next word for the serializer.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (s_accept) begin
      pend_valid <= 1'b1;
    end else if (load_ready) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      pend_item <= new_item;
    end
  end

  i2cft_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .load_valid (pend_valid),
    .load_ready (load_ready),
    .load_item  (pend_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_symbol (symbol),
    .out_last   (m_tlast)
  );

  assign m_tdata = {5'd0, symbol};

  a_frame_flag: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> in_frame == !$past(s_tlast))
    else $error("frame flag does not follow end of payload");

endmodule
